// ===== design/bcce_pkg.sv =====
package bcce_pkg;

  localparam int unsigned NumDots   = 8;
  localparam int unsigned IdW       = 3;
  localparam int unsigned CountW    = 4;
  localparam int unsigned RowW      = 7;
  localparam int unsigned ChanW     = 8;
  localparam int unsigned ColorW    = 24;
  localparam int unsigned CodeW     = 14;
  localparam int unsigned PatternW  = 8;
  localparam int unsigned NumColors = 7;
  localparam int unsigned CfgIdxW   = 3;

  localparam logic [CodeW-1:0] BrailleBase = 14'h2800;

  // braille bit position of each dot, fields ordered left column then right column
  localparam logic [NumDots-1:0][2:0] DotBitPos = {
    3'd7, 3'd5, 3'd4, 3'd3,
    3'd6, 3'd2, 3'd1, 3'd0
  };

  // entry 0 is the colour of layer id 1
  localparam logic [NumColors-1:0][ColorW-1:0] PaletteReset = {
    24'h282832, 24'hEED6AF, 24'h1E90FF, 24'h22B422,
    24'h8B5A2B, 24'hDCDCE6, 24'hFFDC32
  };

  typedef logic [NumDots-1:0][IdW-1:0] dots_t;

  typedef struct packed {
    logic [PatternW-1:0] pattern;
    logic [IdW-1:0]      dom_id;
    logic                is_default;
  } cell_info_t;

  typedef struct packed {
    logic [ChanW-1:0] red;
    logic [ChanW-1:0] green;
    logic [ChanW-1:0] blue;
  } rgb_t;

endpackage

// ===== design/bcce_dominant.sv =====
module bcce_dominant (
  input  bcce_pkg::dots_t      dots_i,
  output bcce_pkg::cell_info_t info_o
);

  logic [bcce_pkg::PatternW-1:0] pattern;
  logic [bcce_pkg::CountW-1:0]   counts [1:bcce_pkg::NumColors];
  logic [bcce_pkg::IdW-1:0]      best_id;
  logic [bcce_pkg::CountW-1:0]   best_cnt;

  always_comb begin
    pattern = '0;
    for (int d = 0; d < bcce_pkg::NumDots; d++) begin
      if (dots_i[d] != '0) begin
        pattern[bcce_pkg::DotBitPos[d]] = 1'b1;
      end
    end
  end

  // one population count per layer id, all in parallel
  always_comb begin
    for (int id = 1; id <= bcce_pkg::NumColors; id++) begin
      counts[id] = '0;
      for (int d = 0; d < bcce_pkg::NumDots; d++) begin
        counts[id] = counts[id] +
                     bcce_pkg::CountW'(dots_i[d] == bcce_pkg::IdW'(id));
      end
    end
  end

  // strict compare keeps the lowest id on a tie
  always_comb begin
    best_id  = '0;
    best_cnt = '0;
    for (int id = 1; id <= bcce_pkg::NumColors; id++) begin
      if (counts[id] > best_cnt) begin
        best_id  = bcce_pkg::IdW'(id);
        best_cnt = counts[id];
      end
    end
  end

  assign info_o.pattern    = pattern;
  assign info_o.dom_id     = best_id;
  assign info_o.is_default = (best_id == '0);

endmodule

// ===== design/bcce_gradient.sv =====
module bcce_gradient (
  input  logic [bcce_pkg::RowW-1:0] row_i,
  output bcce_pkg::rgb_t            bg_o
);

  localparam int unsigned SumW = 10;
  localparam logic [bcce_pkg::RowW-1:0] Band1Start = 7'd40;
  localparam logic [bcce_pkg::RowW-1:0] Band2Start = 7'd50;
  localparam logic [SumW-1:0] ChanMax = 10'd255;

  logic [SumW-1:0] row_w;
  logic [SumW-1:0] off1;
  logic [SumW-1:0] off2;
  logic [SumW-1:0] red_w;
  logic [SumW-1:0] green_w;
  logic [SumW-1:0] blue_w;

  function automatic logic [bcce_pkg::ChanW-1:0] sat8(input logic [SumW-1:0] v);
    return (v > ChanMax) ? bcce_pkg::ChanW'(ChanMax) : v[bcce_pkg::ChanW-1:0];
  endfunction

  assign row_w = SumW'(row_i);
  assign off1  = SumW'(row_i - Band1Start);
  assign off2  = SumW'(row_i - Band2Start);

  always_comb begin
    priority if (row_i < Band1Start) begin
      red_w   = row_w + 10'd8;
      green_w = (row_w << 1) + 10'd12;
      blue_w  = (row_w << 1) + 10'd60;
    end else if (row_i < Band2Start) begin
      red_w   = 10'd5;
      green_w = (off1 << 1) + 10'd20;
      blue_w  = (off1 << 1) + off1 + 10'd80;
    end else begin
      // only this band can run past full scale
      red_w   = (off2 << 1) + off2 + 10'd80;
      green_w = (off2 << 1) + 10'd60;
      blue_w  = 10'd30;
    end
  end

  assign bg_o.red   = sat8(red_w);
  assign bg_o.green = sat8(green_w);
  assign bg_o.blue  = sat8(blue_w);

endmodule

// ===== design/bcce_palette.sv =====
module bcce_palette (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [bcce_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [bcce_pkg::ColorW-1:0]  cfg_data_i,
  input  logic [bcce_pkg::IdW-1:0]     rd_id_i,
  output logic [bcce_pkg::ColorW-1:0]  color_o
);

  logic [bcce_pkg::NumColors-1:0][bcce_pkg::ColorW-1:0] pal_q;
  logic [bcce_pkg::IdW-1:0] rd_idx;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pal_q <= bcce_pkg::PaletteReset;
    end else if (cfg_we_i && (cfg_index_i < bcce_pkg::CfgIdxW'(bcce_pkg::NumColors))) begin
      pal_q[cfg_index_i] <= cfg_data_i;
    end
  end

  assign rd_idx  = bcce_pkg::IdW'(rd_id_i - 3'd1);
  assign color_o = (rd_id_i == '0) ? '0 : pal_q[rd_idx];

endmodule

// ===== design/braille_cell_color_encoder_top.sv =====
// a result passes through the input register, then the result register
// throughput: one cell per cycle while out_stall_i is low, set by that register pair
// with the input register empty, a transfer is taken while a result waits downstream
// reset: pipeline valids clear, palette registers load their default colours
module braille_cell_color_encoder_top (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [bcce_pkg::IdW-1:0]     dot_row0_left_i,
  input  logic [bcce_pkg::IdW-1:0]     dot_row1_left_i,
  input  logic [bcce_pkg::IdW-1:0]     dot_row2_left_i,
  input  logic [bcce_pkg::IdW-1:0]     dot_row3_left_i,
  input  logic [bcce_pkg::IdW-1:0]     dot_row0_right_i,
  input  logic [bcce_pkg::IdW-1:0]     dot_row1_right_i,
  input  logic [bcce_pkg::IdW-1:0]     dot_row2_right_i,
  input  logic [bcce_pkg::IdW-1:0]     dot_row3_right_i,
  input  logic [bcce_pkg::RowW-1:0]    cell_row_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [bcce_pkg::CodeW-1:0]   braille_code_o,
  output logic [bcce_pkg::IdW-1:0]     dominant_id_o,
  output logic                         fg_is_default_o,
  output logic [bcce_pkg::ColorW-1:0]  fg_color_o,
  output logic [bcce_pkg::ChanW-1:0]   bg_red_o,
  output logic [bcce_pkg::ChanW-1:0]   bg_green_o,
  output logic [bcce_pkg::ChanW-1:0]   bg_blue_o,
  input  logic                         cfg_we_i,
  input  logic [bcce_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [bcce_pkg::ColorW-1:0]  cfg_data_i
);

  logic                         s1_valid_q;
  bcce_pkg::dots_t              dots_q;
  logic [bcce_pkg::RowW-1:0]    row_q;
  logic                         out_valid_q;
  logic                         s2_adv;
  logic                         in_accept;

  bcce_pkg::cell_info_t         info;
  bcce_pkg::rgb_t               bg;
  logic [bcce_pkg::ColorW-1:0]  fg_color;

  logic [bcce_pkg::CodeW-1:0]   code_q;
  logic [bcce_pkg::IdW-1:0]     dom_id_q;
  logic                         is_default_q;
  logic [bcce_pkg::ColorW-1:0]  fg_color_q;
  bcce_pkg::rgb_t               bg_q;

  assign s2_adv     = !out_valid_q || !out_stall_i;
  assign in_stall_o = s1_valid_q && !s2_adv;
  assign in_accept  = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      dots_q <= {dot_row3_right_i, dot_row2_right_i, dot_row1_right_i, dot_row0_right_i,
                 dot_row3_left_i, dot_row2_left_i, dot_row1_left_i, dot_row0_left_i};
      row_q  <= cell_row_i;
    end
  end

  bcce_dominant u_dominant (
    .dots_i (dots_q),
    .info_o (info)
  );

  bcce_gradient u_gradient (
    .row_i (row_q),
    .bg_o  (bg)
  );

  bcce_palette u_palette (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .rd_id_i     (info.dom_id),
    .color_o     (fg_color)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s2_adv) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_adv && s1_valid_q) begin
      code_q       <= bcce_pkg::BrailleBase | bcce_pkg::CodeW'(info.pattern);
      dom_id_q     <= info.dom_id;
      is_default_q <= info.is_default;
      fg_color_q   <= fg_color;
      bg_q         <= bg;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign braille_code_o  = code_q;
  assign dominant_id_o   = dom_id_q;
  assign fg_is_default_o = is_default_q;
  assign fg_color_o      = fg_color_q;
  assign bg_red_o        = bg_q.red;
  assign bg_green_o      = bg_q.green;
  assign bg_blue_o       = bg_q.blue;

  // an empty cell carries no dots and no colour
  a_empty_cell: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && fg_is_default_o) |->
      (braille_code_o == bcce_pkg::BrailleBase && fg_color_o == '0 && dominant_id_o == '0))
    else $error("empty cell result inconsistent");

  // a dominant layer needs at least one dot set
  a_dominant_dots: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !fg_is_default_o) |->
      (dominant_id_o != '0 && braille_code_o != bcce_pkg::BrailleBase))
    else $error("dominant id without dots");

  // stall only while an item is held in the input register
  a_stall_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> s1_valid_q)
    else $error("stall with empty input register");

  // an accepted transfer reaches the result register once it is free
  a_accept_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && !out_valid_q) |=> ##1 out_valid_q)
    else $error("accepted transfer lost");

endmodule
